>>> hw/rtl/smo_pkg.sv
package smo_pkg;

    // Word count of the memories; a power of two between 256 and 32768.
    localparam int MEM_WORDS = 32768;
    localparam int ADDR_W    = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        OP_SUBLEQ = 4'd0,
        OP_JMP    = 4'd1,
        OP_ADD    = 4'd2,
        OP_SUB    = 4'd3,
        OP_MOV    = 4'd4,
        OP_ZERO   = 4'd5,
        OP_PUT    = 4'd6,
        OP_GET    = 4'd7,
        OP_HALT   = 4'd8,
        OP_IJMP   = 4'd9,
        OP_ILOAD  = 4'd10,
        OP_ISTORE = 4'd11,
        OP_INC    = 4'd12,
        OP_DEC    = 4'd13,
        OP_INV    = 4'd14,
        OP_BAD    = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_STEP    = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_INV = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [15:0] a;
        logic [15:0] b;
    } alu_req_t;

    // Per-address macro descriptor stored beside each word.
    typedef struct packed {
        op_t         tag;
        logic [14:0] src;
        logic [15:0] dst;
    } meta_t;

    // Words the pc skips after a macro op (length of the replaced sequence).
    function automatic logic [5:0] op_advance(input op_t op);
        logic [5:0] adv;
        unique case (op)
            OP_SUBLEQ, OP_SUB, OP_ZERO, OP_PUT, OP_GET,
            OP_INC, OP_DEC:              adv = 6'd3;
            OP_ADD:                      adv = 6'd9;
            OP_MOV:                      adv = 6'd12;
            OP_INV:                      adv = 6'd21;
            OP_ILOAD:                    adv = 6'd24;
            OP_ISTORE:                   adv = 6'd48;
            default:                     adv = 6'd0;
        endcase
        return adv;
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [15:0] v);
        return v[ADDR_W-1:0];
    endfunction

endpackage

>>> hw/rtl/smo_ram.sv
module smo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/smo_alu.sv
module smo_alu (
    input  smo_pkg::alu_req_t req,
    output logic [15:0]       y,
    output logic              le_zero
);
    import smo_pkg::*;

    always_comb begin
        unique case (req.op)
            ALU_ADD: y = req.a + req.b;
            ALU_SUB: y = req.a - req.b;
            ALU_INV: y = ~req.a;
            default: y = req.a;
        endcase
    end

    // SUBLEQ branch condition: negative or zero.
    assign le_zero = y[15] | (y == 16'd0);

endmodule

>>> hw/rtl/subleq_macro_op_cpu.sv
// SUBLEQ machine with macro tags. Each s_ transfer is a load (writes one word with its
// tag, source and destination), a step (runs one instruction at pc) or a restart (pc back
// to 0, memory kept); every transfer yields exactly one m_ result. The word memory has a
// single port with a registered read, so each operand fetch has its own state. A load or
// restart goes straight to the result state; a step first passes through decode and the
// operand states (plain SUBLEQ arithmetic is the longest: fetch a, b, c, then mem[a],
// mem[b] with write back, then the result). The result state places the result in the
// output register once that register is free. One item is in flight at a time;
// s_tready is low from acceptance until the result has been placed in the output
// register, and that register holds it while m_tready is low. After reset the block
// sweeps all MEM_WORDS addresses to zero, one per cycle, and accepts no item until the
// sweep ends; cfg writes are always taken.
module subleq_macro_op_cpu (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: use_macro_tags
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // action
    input  logic [79:0] s_tdata,   // address[14:0], word[30:15], op_tag[34:31],
                                   // src_addr[49:35], dst_addr[65:50], in_char[73:66],
                                   // in_eof[74], zero fill[79:75]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // out_valid[0], out_char[8:1], in_taken[9], halted[10],
                                   // fault[11], next_pc[27:12], executed_op[31:28]
);
    import smo_pkg::*;

    localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);

    typedef enum logic [3:0] {
        ST_CLEAR,    // post-reset zeroing sweep
        ST_IDLE,
        ST_DECODE,   // tag and mem[pc] available
        ST_R1,       // first operand read returns
        ST_R2,       // second operand read returns
        ST_WZ,       // clear mem[0] after MOV / ADD
        ST_SQ_C,     // SUBLEQ: c returns
        ST_SQ_MA,    // SUBLEQ: mem[a] returns
        ST_SQ_MB,    // SUBLEQ: mem[b] returns
        ST_DONE
    } state_t;

    // input field views
    logic [1:0]  in_action;
    logic [14:0] in_address;
    logic [15:0] in_word;
    logic [3:0]  in_op_tag;
    logic [14:0] in_src;
    logic [15:0] in_dst;
    logic [7:0]  in_char;
    logic        in_eof;

    assign in_action  = s_tuser;
    assign in_address = s_tdata[14:0];
    assign in_word    = s_tdata[30:15];
    assign in_op_tag  = s_tdata[34:31];
    assign in_src     = s_tdata[49:35];
    assign in_dst     = s_tdata[65:50];
    assign in_char    = s_tdata[73:66];
    assign in_eof     = s_tdata[74];

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [15:0]       pc_reg, pc_next;
    logic              stopped_reg, stopped_next;
    logic              use_tags_reg, use_tags_next;
    logic [15:0]       inval_reg, inval_next;
    op_t               op_reg, op_next;
    logic [ADDR_W-1:0] s_reg, s_next;
    logic [15:0]       d_reg, d_next;
    logic [15:0]       a_reg, a_next;
    logic [15:0]       b_reg, b_next;
    logic [15:0]       c_reg, c_next;
    logic [15:0]       x_reg, x_next;
    logic              ov_reg, ov_next;
    logic [7:0]        oc_reg, oc_next;
    logic              taken_reg, taken_next;
    logic              fault_reg, fault_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    // memory ports
    logic              wram_we;
    logic [ADDR_W-1:0] wram_addr;
    logic [15:0]       wram_wdata;
    logic [15:0]       word_q;
    logic              meta_we;
    logic [ADDR_W-1:0] meta_addr;
    meta_t             meta_wdata;
    meta_t             meta_q;

    // shared arithmetic unit
    alu_req_t    alu_req;
    logic [15:0] alu_y;
    logic        alu_le;

    op_t         dec_op;
    op_t         adv_op;
    logic [15:0] pc_step;
    logic        pc_ge;
    logic        halted;
    logic        s_fire;

    smo_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_word_ram (
        .aclk  (aclk),
        .we    (wram_we),
        .addr  (wram_addr),
        .wdata (wram_wdata),
        .rdata (word_q)
    );

    smo_ram #(.WIDTH($bits(meta_t)), .DEPTH(MEM_WORDS)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .addr  (meta_addr),
        .wdata (meta_wdata),
        .rdata (meta_q)
    );

    smo_alu u_alu (
        .req     (alu_req),
        .y       (alu_y),
        .le_zero (alu_le)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign dec_op  = use_tags_reg ? meta_q.tag : OP_SUBLEQ;
    assign adv_op  = (state_reg == ST_DECODE) ? dec_op : op_reg;
    assign pc_step = pc_reg + {10'd0, op_advance(adv_op)};
    assign pc_ge   = ({1'b0, pc_reg} >= MEM_LIMIT);
    assign halted  = stopped_reg | pc_ge;

    // ALU operands: R2 does mem[d] op mem[s], SUBLEQ does mem[b] - mem[a],
    // INC/DEC/INV work on the value just read.
    always_comb begin
        unique case (op_reg)
            OP_SUB, OP_DEC, OP_SUBLEQ: alu_req.op = ALU_SUB;
            OP_INV:                    alu_req.op = ALU_INV;
            default:                   alu_req.op = ALU_ADD;
        endcase
        priority if (state_reg == ST_R2) begin
            alu_req.a = x_reg;
            alu_req.b = word_q;
        end else if (state_reg == ST_SQ_MB) begin
            alu_req.a = word_q;
            alu_req.b = x_reg;
        end else begin
            alu_req.a = word_q;
            alu_req.b = 16'd1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        pc_next       = pc_reg;
        stopped_next  = stopped_reg;
        use_tags_next = cfg_valid ? cfg_data : use_tags_reg;
        inval_next    = inval_reg;
        op_next       = op_reg;
        s_next        = s_reg;
        d_next        = d_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        x_next        = x_reg;
        ov_next       = ov_reg;
        oc_next       = oc_reg;
        taken_next    = taken_reg;
        fault_next    = fault_reg;
        m_tvalid_next = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        wram_we    = 1'b0;
        wram_addr  = wrap_addr(pc_reg);
        wram_wdata = 16'd0;
        meta_we    = 1'b0;
        meta_addr  = wrap_addr(pc_reg);
        meta_wdata = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                wram_we   = 1'b1;
                wram_addr = clr_reg;
                meta_we   = 1'b1;
                meta_addr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(MEM_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_fire) begin
                    ov_next    = 1'b0;
                    oc_next    = 8'd0;
                    taken_next = 1'b0;
                    fault_next = 1'b0;
                    op_next    = OP_SUBLEQ;
                    inval_next = in_eof ? 16'hFFFF : {8'd0, in_char};
                    state_next = ST_DONE;
                    unique case (in_action)
                        ACT_LOAD: begin
                            wram_we    = 1'b1;
                            wram_addr  = wrap_addr({1'b0, in_address});
                            wram_wdata = in_word;
                            meta_we    = 1'b1;
                            meta_addr  = wrap_addr({1'b0, in_address});
                            meta_wdata = '{tag: op_t'(in_op_tag), src: in_src, dst: in_dst};
                        end
                        ACT_RESTART: begin
                            pc_next      = 16'd0;
                            stopped_next = 1'b0;
                        end
                        ACT_STEP: begin
                            // reads of mem[pc] and its tag issue now
                            if (!halted) begin
                                state_next = ST_DECODE;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_DECODE: begin
                op_next    = dec_op;
                s_next     = wrap_addr({1'b0, meta_q.src});
                d_next     = meta_q.dst;
                state_next = ST_R1;
                unique case (dec_op)
                    OP_SUBLEQ: begin
                        a_next    = word_q;
                        wram_addr = wrap_addr(pc_reg) + 1'b1;
                    end
                    OP_JMP: begin
                        wram_we    = 1'b1;
                        wram_addr  = wrap_addr({1'b0, meta_q.src});
                        pc_next    = meta_q.dst;
                        state_next = ST_DONE;
                    end
                    OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_INV, OP_IJMP, OP_ISTORE: begin
                        wram_addr = wrap_addr(meta_q.dst);
                    end
                    OP_MOV, OP_PUT, OP_ILOAD: begin
                        wram_addr = wrap_addr({1'b0, meta_q.src});
                    end
                    OP_ZERO: begin
                        wram_we    = 1'b1;
                        wram_addr  = wrap_addr(meta_q.dst);
                        pc_next    = pc_step;
                        state_next = ST_DONE;
                    end
                    OP_GET: begin
                        wram_we    = 1'b1;
                        wram_addr  = wrap_addr(meta_q.dst);
                        wram_wdata = inval_reg;
                        taken_next = 1'b1;
                        pc_next    = pc_step;
                        state_next = ST_DONE;
                    end
                    OP_HALT: begin
                        stopped_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    default: begin
                        // undefined tag
                        stopped_next = 1'b1;
                        fault_next   = 1'b1;
                        state_next   = ST_DONE;
                    end
                endcase
            end

            ST_R1: begin
                state_next = ST_DONE;
                unique case (op_reg)
                    OP_SUBLEQ: begin
                        b_next     = word_q;
                        wram_addr  = wrap_addr(pc_reg) + 2'd2;
                        state_next = ST_SQ_C;
                    end
                    OP_INC, OP_DEC, OP_INV: begin
                        wram_we    = 1'b1;
                        wram_addr  = wrap_addr(d_reg);
                        wram_wdata = alu_y;
                        pc_next    = pc_step;
                    end
                    OP_IJMP: begin
                        wram_we   = 1'b1;
                        wram_addr = '0;
                        pc_next   = word_q;
                    end
                    OP_MOV: begin
                        wram_we    = 1'b1;
                        wram_addr  = wrap_addr(d_reg);
                        wram_wdata = word_q;
                        pc_next    = pc_step;
                        state_next = ST_WZ;
                    end
                    OP_PUT: begin
                        ov_next = 1'b1;
                        oc_next = word_q[7:0];
                        pc_next = pc_step;
                    end
                    OP_ADD, OP_SUB, OP_ISTORE: begin
                        x_next     = word_q;
                        wram_addr  = s_reg;
                        state_next = ST_R2;
                    end
                    OP_ILOAD: begin
                        // pointer chase: mem[mem[s]]
                        wram_addr  = wrap_addr(word_q);
                        state_next = ST_R2;
                    end
                    default: ;
                endcase
            end

            ST_R2: begin
                state_next = ST_DONE;
                pc_next    = pc_step;
                wram_we    = 1'b1;
                wram_addr  = wrap_addr(d_reg);
                unique case (op_reg)
                    OP_ADD: begin
                        wram_wdata = alu_y;
                        state_next = ST_WZ;
                    end
                    OP_SUB: begin
                        wram_wdata = alu_y;
                    end
                    OP_ISTORE: begin
                        wram_addr  = wrap_addr(x_reg);
                        wram_wdata = word_q;
                    end
                    default: begin
                        // ILOAD
                        wram_wdata = word_q;
                    end
                endcase
            end

            ST_WZ: begin
                wram_we    = 1'b1;
                wram_addr  = '0;
                state_next = ST_DONE;
            end

            ST_SQ_C: begin
                c_next  = word_q;
                pc_next = pc_step;
                if (a_reg == 16'hFFFF) begin
                    wram_we    = 1'b1;
                    wram_addr  = wrap_addr(b_reg);
                    wram_wdata = inval_reg;
                    taken_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    wram_addr  = wrap_addr(a_reg);
                    state_next = ST_SQ_MA;
                end
            end

            ST_SQ_MA: begin
                if (b_reg == 16'hFFFF) begin
                    ov_next    = 1'b1;
                    oc_next    = word_q[7:0];
                    state_next = ST_DONE;
                end else begin
                    x_next     = word_q;
                    wram_addr  = wrap_addr(b_reg);
                    state_next = ST_SQ_MB;
                end
            end

            ST_SQ_MB: begin
                wram_we    = 1'b1;
                wram_addr  = wrap_addr(b_reg);
                wram_wdata = alu_y;
                if (alu_le) begin
                    pc_next = c_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                // pc past the memory stops the machine
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {op_reg, pc_reg, fault_reg, halted, taken_reg,
                                     oc_reg, ov_reg};
                    stopped_next  = halted;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            pc_reg       <= 16'd0;
            stopped_reg  <= 1'b0;
            use_tags_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            pc_reg       <= pc_next;
            stopped_reg  <= stopped_next;
            use_tags_reg <= use_tags_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        inval_reg   <= inval_next;
        op_reg      <= op_next;
        s_reg       <= s_next;
        d_reg       <= d_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        x_reg       <= x_next;
        ov_reg      <= ov_next;
        oc_reg      <= oc_next;
        taken_reg   <= taken_next;
        fault_reg   <= fault_next;
        m_tdata_reg <= m_tdata_next;
    end

    // a fault always leaves the machine stopped
    a_fault_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[11] || m_tdata[10]))
        else $error("fault reported without halted");

    // one item at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new transfer taken while an item is in progress");

    // pc outside memory must be reported as halted
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ({1'b0, m_tdata[27:12]} >= MEM_LIMIT)) |-> m_tdata[10])
        else $error("pc beyond memory without halted");

    // a single instruction never both prints and consumes input
    a_io_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
        else $error("output and input in the same result");

endmodule
